[rtl/core/heightmap_bilinear_sampler_defines.svh]
// Assertion macros for the heightmap bilinear sampler.
// Define ASSERT_OFF to compile the checks out; expects clk and rst_n in scope.
`ifndef HEIGHTMAP_BILINEAR_SAMPLER_DEFINES_SVH
`define HEIGHTMAP_BILINEAR_SAMPLER_DEFINES_SVH

`ifndef ASSERT_OFF

// Check held at every clock edge outside reset
`define HBS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check held at every clock edge, reset included
`define HBS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define HBS_ASSERT(lbl, prop, msg)
`define HBS_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

[rtl/core/hbs_pkg.sv]
// Shared types and constants for the heightmap bilinear sampler.
// No dependencies.
`timescale 1ns / 1ps

package hbs_pkg;

    // Field widths
    localparam int EXTENT_W   = 9;     // grid_width / grid_depth registers
    localparam int SCALE_W    = 16;    // inverse_scale, unsigned Q8.8
    localparam int INDEX_W    = 16;    // load_index
    localparam int HEIGHT_W   = 16;    // heights, unsigned Q8.8
    localparam int POS_W      = 24;    // positions, signed Q15.8
    localparam int FRAC_W     = 8;     // grid fraction bits
    localparam int COORD_W    = EXTENT_W + FRAC_W;     // clamped grid coordinate
    localparam int PROD_W     = POS_W + SCALE_W + 1;   // signed position * scale
    localparam int SUM_W      = PROD_W - FRAC_W + 1;   // shifted product plus centre
    localparam int WEIGHT_W   = FRAC_W + 1;            // blend weight 0..256
    localparam int H1D_W      = HEIGHT_W + FRAC_W;     // horizontal blend, Q8.16
    localparam int H2D_W      = HEIGHT_W + 2 * FRAC_W; // vertical blend, Q8.24
    localparam int ROWADDR_W  = 2 * EXTENT_W + 1;      // z0 * w + x0

    // Stream and configuration port widths
    localparam int S_TDATA_W  = 2 * INDEX_W + 2 * POS_W;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_GRID_WIDTH    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_GRID_DEPTH    = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_INVERSE_SCALE = 2'd2;

    // Reset values
    localparam logic [EXTENT_W-1:0] EXTENT_RESET = 9'd256;
    localparam logic [SCALE_W-1:0]  SCALE_RESET  = 16'd256;

    // Item kinds carried on tuser
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // Blend constants
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 9'd256;
    localparam logic [H2D_W-1:0]    ROUND_HALF = 32'h0000_8000;

endpackage

[rtl/core/heightmap_bilinear_sampler.sv]
// Heightmap bilinear sampler top level: six-stage pipeline around a duplicated height store.
// Depends on hbs_pkg and heightmap_bilinear_sampler_defines.svh.
`timescale 1ns / 1ps
`include "heightmap_bilinear_sampler_defines.svh"

// Takes one item per clock, loads and queries alike, while the output is not
// stalled; a query's result passes stages 1 to 5 and the output register. The whole
// pipeline moves on one enable, so a stalled output freezes every stage and
// s_tready drops. Loads travel stages 1 to 3 with queries and write the store at
// the stage where queries read it, so every query sees exactly the loads that came
// before it. The store is held twice, MAX_GRID_WIDTH * MAX_GRID_DEPTH entries each;
// every load writes both copies, and per query one copy delivers the two samples
// of the lower row and the other the two of the upper row. The store has no reset
// and must be loaded over the used grid before it is queried. Extents outside
// 2..MAX are clamped when written.
module heightmap_bilinear_sampler #(
    parameter int MAX_GRID_WIDTH = 256,
    parameter int MAX_GRID_DEPTH = 256
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration write port
    input  logic                            cfg_wr_en,
    input  logic [hbs_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [hbs_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // input items
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // load_index[15:0], load_height[31:16], pos_x[55:32], pos_z[79:56]
    input  logic [hbs_pkg::S_TDATA_W-1:0]   s_tdata,
    // action[0]
    input  logic                            s_tuser,
    // result items
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // height[15:0]
    output logic [hbs_pkg::HEIGHT_W-1:0]    m_tdata
);

    import hbs_pkg::*;

    localparam int STORE_SIZE = MAX_GRID_WIDTH * MAX_GRID_DEPTH;
    localparam int ADDR_W     = $clog2(STORE_SIZE);
    localparam logic [EXTENT_W-1:0] WIDTH_RESET =
        (MAX_GRID_WIDTH < 256) ? EXTENT_W'(MAX_GRID_WIDTH) : EXTENT_RESET;
    localparam logic [EXTENT_W-1:0] DEPTH_RESET =
        (MAX_GRID_DEPTH < 256) ? EXTENT_W'(MAX_GRID_DEPTH) : EXTENT_RESET;

    // Extent clamp to 2..max, done once at write time
    function automatic logic [EXTENT_W-1:0] clamp_extent(
        input logic [EXTENT_W-1:0] e,
        input int                  maxv
    );
        logic [EXTENT_W-1:0] r;
        if (e < EXTENT_W'(2))
            r = EXTENT_W'(2);
        else if (32'(e) > 32'(maxv))
            r = EXTENT_W'(maxv);
        else
            r = e;
        return r;
    endfunction

    // World product to clamped grid coordinate: floor(p / 256) + ext * 128,
    // clamped to 0 .. (ext - 1) * 256 - 1
    function automatic logic [COORD_W-1:0] to_grid(
        input logic signed [PROD_W-1:0] p,
        input logic [EXTENT_W-1:0]      ext
    );
        logic signed [SUM_W-2:0] q;
        logic signed [SUM_W-1:0] sum;
        logic signed [SUM_W-1:0] hi;
        logic [COORD_W-1:0]      r;
        q   = $signed(p[PROD_W-1:FRAC_W]);
        sum = $signed({q[SUM_W-2], q})
            + $signed({{(SUM_W-EXTENT_W-FRAC_W+1){1'b0}}, ext, {(FRAC_W-1){1'b0}}});
        hi  = $signed({{(SUM_W-COORD_W){1'b0}}, ext - EXTENT_W'(1), {FRAC_W{1'b0}}});
        if (sum < 0)
            r = '0;
        else if (sum >= hi)
            r = COORD_W'(hi - SUM_W'(1));
        else
            r = sum[COORD_W-1:0];
        return r;
    endfunction

    // Configuration registers
    logic [EXTENT_W-1:0] grid_width_reg;
    logic [EXTENT_W-1:0] grid_depth_reg;
    logic [SCALE_W-1:0]  inverse_scale_reg;

    // Pipeline stage registers
    logic                     st1_valid_reg;
    logic                     st1_query_reg;
    logic [INDEX_W-1:0]       st1_index_reg;
    logic [HEIGHT_W-1:0]      st1_height_reg;
    logic signed [PROD_W-1:0] st1_px_reg;
    logic signed [PROD_W-1:0] st1_pz_reg;

    logic                     st2_valid_reg;
    logic                     st2_query_reg;
    logic [INDEX_W-1:0]       st2_index_reg;
    logic [HEIGHT_W-1:0]      st2_height_reg;
    logic [COORD_W-1:0]       st2_u_reg;
    logic [COORD_W-1:0]       st2_v_reg;

    logic                     st3_valid_reg;
    logic                     st3_query_reg;
    logic                     st3_wr_ok_reg;
    logic [ADDR_W-1:0]        st3_addr_reg;
    logic [HEIGHT_W-1:0]      st3_height_reg;
    logic [FRAC_W-1:0]        st3_tx_reg;
    logic [FRAC_W-1:0]        st3_tz_reg;

    logic                     st4_valid_reg;
    logic [FRAC_W-1:0]        st4_tx_reg;
    logic [FRAC_W-1:0]        st4_tz_reg;
    logic [HEIGHT_W-1:0]      h00_reg;
    logic [HEIGHT_W-1:0]      h10_reg;
    logic [HEIGHT_W-1:0]      h01_reg;
    logic [HEIGHT_W-1:0]      h11_reg;

    logic                     st5_valid_reg;
    logic [FRAC_W-1:0]        st5_tz_reg;
    logic [H1D_W-1:0]         h0_reg;
    logic [H1D_W-1:0]         h1_reg;

    logic                     out_valid_reg;
    logic [HEIGHT_W-1:0]      out_height_reg;

    // Next values
    logic                     advance;
    logic signed [PROD_W-1:0] px_next;
    logic signed [PROD_W-1:0] pz_next;
    logic [COORD_W-1:0]       u_next;
    logic [COORD_W-1:0]       v_next;
    logic [ROWADDR_W-1:0]     row_addr_next;
    logic [ADDR_W-1:0]        addr_next;
    logic                     wr_ok_next;
    logic [ADDR_W-1:0]        addr_right;
    logic [ADDR_W-1:0]        addr_up;
    logic [ADDR_W-1:0]        addr_up_right;
    logic [H1D_W-1:0]         h0_next;
    logic [H1D_W-1:0]         h1_next;
    logic [H2D_W-1:0]         h_next;
    logic                     mem_wr;
    logic                     mem_rd;

    // Height store, two copies
    logic [HEIGHT_W-1:0] mem_lo [STORE_SIZE];
    logic [HEIGHT_W-1:0] mem_hi [STORE_SIZE];

    // Whole pipeline moves unless a finished result is stuck
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_height_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg    <= WIDTH_RESET;
            grid_depth_reg    <= DEPTH_RESET;
            inverse_scale_reg <= SCALE_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                REG_GRID_WIDTH:
                    grid_width_reg <= clamp_extent(cfg_wdata[EXTENT_W-1:0], MAX_GRID_WIDTH);
                REG_GRID_DEPTH:
                    grid_depth_reg <= clamp_extent(cfg_wdata[EXTENT_W-1:0], MAX_GRID_DEPTH);
                REG_INVERSE_SCALE:
                    inverse_scale_reg <= cfg_wdata[SCALE_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // Stage 1: position times reciprocal scale
    assign px_next = $signed(s_tdata[2*INDEX_W +: POS_W])
                   * $signed({1'b0, inverse_scale_reg});
    assign pz_next = $signed(s_tdata[2*INDEX_W+POS_W +: POS_W])
                   * $signed({1'b0, inverse_scale_reg});

    // Stage 2: grid coordinates, clamped
    assign u_next = to_grid(st1_px_reg, grid_width_reg);
    assign v_next = to_grid(st1_pz_reg, grid_depth_reg);

    // Stage 3: store address of the lower left sample, or the load address
    assign row_addr_next = ROWADDR_W'(st2_v_reg[COORD_W-1:FRAC_W]) * ROWADDR_W'(grid_width_reg)
                         + ROWADDR_W'(st2_u_reg[COORD_W-1:FRAC_W]);
    assign wr_ok_next    = 32'(st2_index_reg) < 32'(STORE_SIZE);

    always_comb
    begin
        logic [31:0] wide;
        if (st2_query_reg)
            wide = 32'(row_addr_next);
        else
            wide = 32'(st2_index_reg);
        addr_next = wide[ADDR_W-1:0];
    end

    // Neighbour addresses; always inside the store thanks to the clamp
    always_comb
    begin
        logic [31:0] w_wide;
        w_wide        = 32'(grid_width_reg);
        addr_right    = st3_addr_reg + ADDR_W'(1);
        addr_up       = st3_addr_reg + w_wide[ADDR_W-1:0];
        addr_up_right = addr_up + ADDR_W'(1);
    end

    assign mem_wr = advance && st3_valid_reg && !st3_query_reg && st3_wr_ok_reg;
    assign mem_rd = advance && st3_valid_reg && st3_query_reg;

    // Lower row copy
    always_ff @(posedge clk)
    begin
        if (mem_wr)
            mem_lo[st3_addr_reg] <= st3_height_reg;
        if (mem_rd)
        begin
            h00_reg <= mem_lo[st3_addr_reg];
            h10_reg <= mem_lo[addr_right];
        end
    end

    // Upper row copy
    always_ff @(posedge clk)
    begin
        if (mem_wr)
            mem_hi[st3_addr_reg] <= st3_height_reg;
        if (mem_rd)
        begin
            h01_reg <= mem_hi[addr_up];
            h11_reg <= mem_hi[addr_up_right];
        end
    end

    // Stage 5: horizontal blends, exact in Q8.16
    assign h0_next = H1D_W'(h00_reg) * H1D_W'(WEIGHT_ONE - WEIGHT_W'(st4_tx_reg))
                   + H1D_W'(h10_reg) * H1D_W'(st4_tx_reg);
    assign h1_next = H1D_W'(h01_reg) * H1D_W'(WEIGHT_ONE - WEIGHT_W'(st4_tx_reg))
                   + H1D_W'(h11_reg) * H1D_W'(st4_tx_reg);

    // Stage 6: vertical blend, rounded half up to Q8.8
    assign h_next = H2D_W'(h0_reg) * H2D_W'(WEIGHT_ONE - WEIGHT_W'(st5_tz_reg))
                  + H2D_W'(h1_reg) * H2D_W'(st5_tz_reg)
                  + ROUND_HALF;

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
            st3_valid_reg <= 1'b0;
            st4_valid_reg <= 1'b0;
            st5_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            st1_valid_reg <= s_tvalid;
            st2_valid_reg <= st1_valid_reg;
            st3_valid_reg <= st2_valid_reg;
            st4_valid_reg <= st3_valid_reg && st3_query_reg;
            st5_valid_reg <= st4_valid_reg;
            out_valid_reg <= st5_valid_reg;
        end
    end

    // Payload stages
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            st1_query_reg  <= (s_tuser == ACT_QUERY);
            st1_index_reg  <= s_tdata[0 +: INDEX_W];
            st1_height_reg <= s_tdata[INDEX_W +: HEIGHT_W];
            st1_px_reg     <= px_next;
            st1_pz_reg     <= pz_next;

            st2_query_reg  <= st1_query_reg;
            st2_index_reg  <= st1_index_reg;
            st2_height_reg <= st1_height_reg;
            st2_u_reg      <= u_next;
            st2_v_reg      <= v_next;

            st3_query_reg  <= st2_query_reg;
            st3_wr_ok_reg  <= wr_ok_next;
            st3_addr_reg   <= addr_next;
            st3_height_reg <= st2_height_reg;
            st3_tx_reg     <= st2_u_reg[FRAC_W-1:0];
            st3_tz_reg     <= st2_v_reg[FRAC_W-1:0];

            st4_tx_reg     <= st3_tx_reg;
            st4_tz_reg     <= st3_tz_reg;

            st5_tz_reg     <= st4_tz_reg;
            h0_reg         <= h0_next;
            h1_reg         <= h1_next;

            out_height_reg <= h_next[H2D_W-1:H2D_W-HEIGHT_W];
        end
    end

    // Checks
    `HBS_ASSERT(a_cell_in_grid,
        st2_valid_reg && st2_query_reg |->
            (st2_u_reg[COORD_W-1:FRAC_W] <= grid_width_reg - EXTENT_W'(2)) &&
            (st2_v_reg[COORD_W-1:FRAC_W] <= grid_depth_reg - EXTENT_W'(2)),
        "query cell outside the grid after clamping")
    `HBS_ASSERT(a_read_in_store,
        st3_valid_reg && st3_query_reg |->
            32'(st3_addr_reg) + 32'(grid_width_reg) + 32'd1 < 32'(STORE_SIZE),
        "store read beyond the last entry")
    `HBS_ASSERT(a_stall_freezes,
        !advance |=> $stable(st4_valid_reg) && $stable(st5_valid_reg) && $stable(h0_reg),
        "pipeline moved while the output was stalled")
    `HBS_ASSERT_ALWAYS(a_ready_when_free,
        !out_valid_reg |-> s_tready,
        "input refused with an empty output register")

endmodule

[tb/heightmap_bilinear_sampler_checker.sv]
// Checker for the heightmap bilinear sampler: watches the configuration port and both
// item channels, predicts each queried height and compares it with the result items.
// Depends on hbs_pkg.
`timescale 1ns / 1ps

module heightmap_bilinear_sampler_checker
    import hbs_pkg::*;
#(
    parameter int MAX_W = 256,
    parameter int MAX_D = 256
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                    s_tvalid,
    input  logic                    s_tready,
    // load_index[15:0], load_height[31:16], pos_x[55:32], pos_z[79:56]
    input  logic [S_TDATA_W-1:0]    s_tdata,
    // action[0]
    input  logic                    s_tuser,
    input  logic                    m_tvalid,
    input  logic                    m_tready,
    // height[15:0]
    input  logic [HEIGHT_W-1:0]     m_tdata,
    output int                      fail_count,
    output int                      pending,
    output int                      heights_checked
);

    // Shadow copy of the registers and the sample store
    logic [EXTENT_W-1:0]    width_reg;
    logic [EXTENT_W-1:0]    depth_reg;
    logic [SCALE_W-1:0]     scale_reg;
    logic [HEIGHT_W-1:0]    height_mem [0:MAX_W*MAX_D-1];
    logic [HEIGHT_W-1:0]    expected_heights [$];
    logic [HEIGHT_W-1:0]    want;

    // Extent as the block uses it: limited to 2..max
    function automatic int usable_extent(input logic [EXTENT_W-1:0] raw, input int limit);
        int e;
        e = int'(raw);
        if (e < 2)
            return 2;
        if (e > limit)
            return limit;
        return e;
    endfunction

    // World position (Q15.8) to grid coordinate with 8 fraction bits, clamped
    function automatic int grid_coord(input logic signed [POS_W-1:0] pos, input int extent);
        longint prod;
        longint q;
        longint hi;
        prod = longint'(pos) * longint'(scale_reg);
        q = (prod >>> 8) + longint'(extent) * 128;   // floor, then offset to the centre
        hi = longint'(extent - 1) * 256;
        if (q < 0)
            q = 0;
        if (q >= hi)
            q = hi - 1;
        return int'(q);
    endfunction

    // Bilinear blend of the four samples round the query point, rounded half up once
    function automatic logic [HEIGHT_W-1:0] bilinear_height(input logic signed [POS_W-1:0] px,
                                                            input logic signed [POS_W-1:0] pz);
        int w;
        int d;
        int u;
        int v;
        int base;
        longint tx;
        longint tz;
        longint row0;
        longint row1;
        longint mix;
        w = usable_extent(width_reg, MAX_W);
        d = usable_extent(depth_reg, MAX_D);
        u = grid_coord(px, w);
        v = grid_coord(pz, d);
        tx = longint'(u & 255);
        tz = longint'(v & 255);
        base = (v >> 8) * w + (u >> 8);
        row0 = longint'(height_mem[base]) * (256 - tx) + longint'(height_mem[base + 1]) * tx;
        row1 = longint'(height_mem[base + w]) * (256 - tx)
             + longint'(height_mem[base + w + 1]) * tx;
        mix = row0 * (256 - tz) + row1 * tz;
        mix = (mix + 32768) >> 16;
        if (mix > 65535)
            mix = 65535;
        return 16'(mix);
    endfunction

    // Track registers, loads and queries; compare result items in order
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            width_reg = EXTENT_RESET;
            depth_reg = EXTENT_RESET;
            scale_reg = SCALE_RESET;
            expected_heights.delete();
            fail_count = 0;
            pending = 0;
            heights_checked = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_addr)
                    REG_GRID_WIDTH:    width_reg = cfg_wdata[EXTENT_W-1:0];
                    REG_GRID_DEPTH:    depth_reg = cfg_wdata[EXTENT_W-1:0];
                    REG_INVERSE_SCALE: scale_reg = cfg_wdata[SCALE_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                if (s_tuser == ACT_LOAD)
                    height_mem[s_tdata[15:0]] = s_tdata[31:16];
                else
                    expected_heights.push_back(bilinear_height(s_tdata[55:32], s_tdata[79:56]));
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_heights.size() == 0)
                begin
                    $error("unexpected result item: height %0d with no query outstanding",
                           m_tdata);
                    fail_count++;
                end
                else
                begin
                    want = expected_heights.pop_front();
                    heights_checked++;
                    if (m_tdata !== want)
                    begin
                        $error("height mismatch: expected %0d, actual %0d", want, m_tdata);
                        fail_count++;
                    end
                end
            end
            pending = expected_heights.size();
        end
    end

endmodule

[tb/tb_heightmap_bilinear_sampler.sv]
// Testbench top for the heightmap bilinear sampler: clock, reset, configuration,
// load and query stimulus with bursty input and stalling output, and the verdict.
// Depends on hbs_pkg, heightmap_bilinear_sampler and heightmap_bilinear_sampler_checker.
`timescale 1ns / 1ps

module tb_heightmap_bilinear_sampler;
    import hbs_pkg::*;

    localparam int GRID_MAX_W    = 256;
    localparam int GRID_MAX_D    = 256;
    localparam int HOLD_CYCLES   = 80;
    localparam int SETTLE_CYCLES = 12;
    localparam int TAIL_CYCLES   = 20;
    localparam int NUM_SETTINGS  = 10;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    // load_index[15:0], load_height[31:16], pos_x[55:32], pos_z[79:56]
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    // action[0]
    logic                   s_tuser = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // height[15:0]
    logic [HEIGHT_W-1:0]    m_tdata;

    int fail_count;
    int pending;
    int heights_checked;

    // Stimulus-side view of the grid, used to keep queries on written samples
    int                 eff_w = 256;
    int                 eff_d = 256;
    logic [SCALE_W-1:0] cur_scale = SCALE_RESET;
    bit                 loaded [0:GRID_MAX_W*GRID_MAX_D-1];
    int                 burst_left = 0;
    int                 item_count = 0;
    int                 load_count = 0;
    int                 query_count = 0;
    int                 settings_count = 0;
    bit                 hold_req = 1'b0;

    heightmap_bilinear_sampler #(
        .MAX_GRID_WIDTH (GRID_MAX_W),
        .MAX_GRID_DEPTH (GRID_MAX_D)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    heightmap_bilinear_sampler_checker #(
        .MAX_W (GRID_MAX_W),
        .MAX_D (GRID_MAX_D)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .fail_count      (fail_count),
        .pending         (pending),
        .heights_checked (heights_checked)
    );

    // 100 MHz clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard limit on the run
    initial
    begin
        #3_000_000;
        $display("[heightmap_bilinear_sampler] ERROR");
        $finish;
    end

    // Output side: changing stall pattern, plus one long hold-off on request
    initial
    begin : sink_pattern
        int mode;
        int left;
        mode = 0;
        left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            if (left == 0)
            begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(8, 60);
            end
            left--;
            case (mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                2:       m_tready <= ($urandom_range(0, 9) != 0);
                default: m_tready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    function automatic int effective_extent(input logic [CFG_DATA_W-1:0] raw, input int limit);
        int e;
        e = int'(raw[EXTENT_W-1:0]);
        if (e < 2)
            return 2;
        if (e > limit)
            return limit;
        return e;
    endfunction

    // Clamped grid coordinate of a position, to find the samples a query will read
    function automatic int grid_pos(input logic signed [POS_W-1:0] pos, input int extent);
        longint q;
        longint hi;
        q = ((longint'(pos) * longint'(cur_scale)) >>> 8) + longint'(extent) * 128;
        hi = longint'(extent - 1) * 256;
        if (q < 0)
            q = 0;
        if (q >= hi)
            q = hi - 1;
        return int'(q);
    endfunction

    // Position aimed mostly at the grid and a little beyond its edges
    function automatic logic [POS_W-1:0] pick_pos(input int extent);
        longint g;
        longint p;
        if (cur_scale == '0 || $urandom_range(0, 6) == 0)
            return 24'($urandom);
        g = longint'($urandom_range(0, (extent + 2) * 256)) - 256;
        p = ((g - longint'(extent) * 128) * 256) / longint'(cur_scale)
          + longint'($urandom_range(0, 4)) - 2;
        if (p > 8388607)
            p = 8388607;
        if (p < -8388608)
            p = -8388608;
        return 24'(p);
    endfunction

    function automatic logic [HEIGHT_W-1:0] pick_height();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Write all three registers back to back; block must be idle
    task automatic set_grid(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] d,
                            input logic [CFG_DATA_W-1:0] s);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= REG_GRID_WIDTH;
        cfg_wdata <= w;
        @(negedge clk);
        cfg_addr  <= REG_GRID_DEPTH;
        cfg_wdata <= d;
        @(negedge clk);
        cfg_addr  <= REG_INVERSE_SCALE;
        cfg_wdata <= s;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        eff_w = effective_extent(w, GRID_MAX_W);
        eff_d = effective_extent(d, GRID_MAX_D);
        cur_scale = s;
        settings_count++;
    endtask

    // Offer one item; gaps fall between bursts of random length
    task automatic offer_item(input logic kind, input logic [INDEX_W-1:0] idx,
                              input logic [HEIGHT_W-1:0] hgt, input logic [POS_W-1:0] px,
                              input logic [POS_W-1:0] pz);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 7);
            if (gap != 0)
            begin
                @(negedge clk) s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? 48 : $urandom_range(1, 16);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {pz, px, hgt, idx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        burst_left--;
        item_count++;
        if (kind == ACT_LOAD)
        begin
            loaded[idx] = 1'b1;
            load_count++;
        end
        else
            query_count++;
    endtask

    task automatic offer_load(input logic [INDEX_W-1:0] idx, input logic [HEIGHT_W-1:0] hgt);
        offer_item(ACT_LOAD, idx, hgt, 24'($urandom), 24'($urandom));
    endtask

    // Query, preceded by loads of any of its four samples not yet written
    task automatic issue_query(input logic [POS_W-1:0] px, input logic [POS_W-1:0] pz);
        int base;
        int corner [4];
        base = (grid_pos(pz, eff_d) >> 8) * eff_w + (grid_pos(px, eff_w) >> 8);
        corner[0] = base;
        corner[1] = base + 1;
        corner[2] = base + eff_w;
        corner[3] = base + eff_w + 1;
        foreach (corner[k])
            if (!loaded[corner[k]])
                offer_load(16'(corner[k]), pick_height());
        offer_item(ACT_QUERY, 16'($urandom), 16'($urandom), px, pz);
    endtask

    // Stop offering, wait for every result, then let the pipeline empty of loads
    task automatic drain_and_settle();
        @(negedge clk) s_tvalid <= 1'b0;
        burst_left = 0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Stimulus and verdict
    initial
    begin : stimulus
        logic [POS_W-1:0]       probe_x [10];
        logic [POS_W-1:0]       probe_z [10];
        logic [CFG_DATA_W-1:0]  w;
        logic [CFG_DATA_W-1:0]  d;
        logic [CFG_DATA_W-1:0]  s;
        int                     budget;
        int                     start;
        probe_x = '{24'sd0, -24'sd8388608, 24'sd8388607, -24'sd512, -24'sd513,
                    24'sd254, 24'sd255, 24'sd256, -24'sd300, 24'sd127};
        probe_z = '{24'sd0, -24'sd8388608, 24'sd8388607, -24'sd384, -24'sd385,
                    24'sd126, 24'sd127, 24'sd128, 24'sd200, -24'sd77};

        repeat (3) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        for (int ph = 0; ph < NUM_SETTINGS; ph++)
        begin
            case (ph)
                0: begin w = 4;   d = 3;   s = 256;   budget = 50;  end
                1: begin w = 2;   d = 2;   s = 256;   budget = 70;  end
                2: begin w = 256; d = 256; s = 256;   budget = 130; end
                3: begin w = 256; d = 2;   s = 65535; budget = 100; end
                4: begin w = 2;   d = 256; s = 1;     budget = 100; end
                5: begin w = 0;   d = 1;   s = 0;     budget = 60;  end
                6: begin w = 511; d = 300; s = 700;   budget = 100; end
                7:
                begin
                    w = 16'($urandom_range(2, 24));
                    d = 16'($urandom_range(2, 24));
                    s = 16'($urandom_range(1, 1023));
                    budget = 120;
                end
                8:
                begin
                    w = 16'($urandom);
                    d = 16'($urandom);
                    s = 16'($urandom);
                    budget = 100;
                end
                default: begin w = 16; d = 8; s = 384; budget = 120; end
            endcase
            if (ph != 0)
                drain_and_settle();
            set_grid(w, d, s);

            if (ph == 0)
            begin
                // Whole 4x3 grid with both height extremes, and the top store address
                for (int i = 0; i < 12; i++)
                    offer_load(16'(i), (i == 0) ? 16'h0000 : (i == 1) ? 16'hFFFF : 16'($urandom));
                offer_load(16'hFFFF, 16'hFFFF);
                // Centre, position extremes, clamps either side of each edge, fractions
                for (int i = 0; i < 10; i++)
                    issue_query(probe_x[i], probe_z[i]);
                // Full-scale samples round one cell: blend must come out at full scale
                offer_load(16'd5, 16'hFFFF);
                offer_load(16'd6, 16'hFFFF);
                offer_load(16'd9, 16'hFFFF);
                offer_load(16'd10, 16'hFFFF);
                issue_query(-24'sd128, 24'sd0);
            end

            if (ph == NUM_SETTINGS - 1)
            begin
                // Long output hold-off while the input keeps offering items
                hold_req = 1'b1;
                burst_left = 60;
            end

            start = item_count;
            while (item_count - start < budget)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    if ($urandom_range(0, 2) == 0)
                        offer_load(16'($urandom), pick_height());
                    else
                        offer_load(16'($urandom_range(0, eff_w * eff_d - 1)), pick_height());
                end
                else
                    issue_query(pick_pos(eff_w), pick_pos(eff_d));
            end
        end

        drain_and_settle();
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("Ran %0d grid settings (extents below, at and above range, scale 0 to 65535)",
                 settings_count);
        $display("with %0d loads and %0d queries; %0d heights compared.",
                 load_count, query_count, heights_checked);
        if (fail_count == 0 && pending == 0)
            $display("[heightmap_bilinear_sampler] OK");
        else
            $display("[heightmap_bilinear_sampler] ERROR");
        $finish;
    end

endmodule
